@@ rtl/sliding_window_median_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the sliding window median block.
// Each macro expects i_clk and i_rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

// invariant that holds at every edge out of reset
`define SWM_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// same-cycle implication
`define SWM_CHECK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWM_CHECK_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/swm_pkg.sv @@
// ---------------------------------------------------------------------------
// swm_pkg
// Shared constants, types and sequencer states of the sliding window median.
// ---------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

    // window depth and field widths
    localparam int WINDOW      = 10;
    localparam int SAMPLE_W    = 16;
    localparam int MED_W       = SAMPLE_W + 1;
    localparam int FILL_W      = 4;
    localparam int CNT_W       = $clog2(WINDOW + 1);
    localparam int IDX_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((MED_W + FILL_W + 7) / 8) * 8;
    localparam int PAD_W       = OUT_TDATA_W - MED_W - FILL_W;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [MED_W-1:0]    t_med;
    typedef logic [CNT_W-1:0]           t_cnt;
    typedef logic [IDX_W-1:0]           t_idx;

    // window store status toward the sorter
    typedef struct packed {
        t_sample old;    // oldest entry, which the current request overwrites once full
        logic    full;   // window already full before the request
        t_cnt    m;      // count before the request
        t_cnt    n;      // count after the request
    } t_ring_sts;

    // sequencer commands to the sorter
    typedef struct packed {
        logic start;
        logic run;
    } t_sort_ctl;

    // sorter status back to the sequencer
    typedef struct packed {
        logic    done;
        t_sample lo;
        t_sample hi;
        t_cnt    n;
    } t_sort_sts;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SUM
    } t_swm_state;

endpackage

`default_nettype wire

@@ rtl/swm_ring.sv @@
// ---------------------------------------------------------------------------
// swm_ring
// Circular window store with fill count and oldest-slot pointer.
// ---------------------------------------------------------------------------
`default_nettype none

module swm_ring (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_wr,
    input  logic signed [swm_pkg::SAMPLE_W-1:0]    i_sample,
    output swm_pkg::t_ring_sts                     o_sts
);
    import swm_pkg::*;

    `include "sliding_window_median_assert.svh"

    t_sample r_win [WINDOW];
    t_cnt    r_held;
    t_cnt    n_held;
    t_idx    r_oldest;
    t_idx    n_oldest;
    logic    full;
    t_idx    wr_idx;

    assign full   = (r_held == t_cnt'(WINDOW));
    assign wr_idx = full ? r_oldest : r_held[IDX_W-1:0];

    // sample store, append while filling, overwrite oldest once full
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_win[wr_idx] <= i_sample;
        end
    end

    // pointer update
    always_comb begin
        n_held   = r_held;
        n_oldest = r_oldest;
        if (i_wr) begin
            if (!full) begin
                n_held = r_held + t_cnt'(1);
            end else if (r_oldest == t_idx'(WINDOW - 1)) begin
                n_oldest = '0;
            end else begin
                n_oldest = r_oldest + t_idx'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_oldest <= '0;
        end else begin
            r_held   <= n_held;
            r_oldest <= n_oldest;
        end
    end

    // status seen by the sorter at the request
    assign o_sts.old  = r_win[r_oldest];
    assign o_sts.full = full;
    assign o_sts.m    = r_held;
    assign o_sts.n    = full ? t_cnt'(WINDOW) : r_held + t_cnt'(1);

    `SWM_CHECK(a_held_range, r_held <= t_cnt'(WINDOW), "fill count beyond window")
    `SWM_CHECK_IMP(a_oldest_full, r_oldest != '0, full, "oldest pointer moved before full")

endmodule

`default_nettype wire

@@ rtl/swm_sort.sv @@
// ---------------------------------------------------------------------------
// swm_sort
// Ping-pong sorted list; one entry per cycle through a shared compare unit
// drops the oldest value, merges the new sample and captures the middle pair.
// ---------------------------------------------------------------------------
`default_nettype none

module swm_sort (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  swm_pkg::t_sort_ctl                     i_ctl,
    input  logic signed [swm_pkg::SAMPLE_W-1:0]    i_sample,
    input  swm_pkg::t_ring_sts                     i_ring,
    output swm_pkg::t_sort_sts                     o_sts
);
    import swm_pkg::*;

    `include "sliding_window_median_assert.svh"

    t_sample r_b0 [WINDOW];
    t_sample r_b1 [WINDOW];
    logic    r_bank;          // bank holding the current sorted list
    logic    n_bank;
    t_cnt    r_k;             // write position in the new list
    t_cnt    n_k;
    t_cnt    r_r;             // read position in the old list
    t_cnt    n_r;
    t_cnt    r_m;
    t_cnt    n_m;
    t_cnt    r_n;
    t_cnt    n_n;
    logic    r_ins_done;
    logic    n_ins_done;
    logic    r_rem_done;
    logic    n_rem_done;
    t_sample r_s;
    t_sample r_x;
    t_sample r_lo;
    t_sample r_hi;

    t_sample a;
    logic    a_ok;
    logic    a_eq_x;
    logic    s_le_a;
    logic    skip;
    logic    take_s;
    logic    done;
    logic    step;
    logic    wr_en;
    t_sample w;
    t_cnt    mid;

    // shared compare unit on the entry under the read pointer
    assign a      = r_bank ? r_b1[r_r[IDX_W-1:0]] : r_b0[r_r[IDX_W-1:0]];
    assign a_ok   = (r_r < r_m);
    assign a_eq_x = (a == r_x);
    assign s_le_a = !(a < r_s);

    assign done   = (r_k == r_n);
    assign step   = i_ctl.run && !done;
    assign skip   = !r_rem_done && a_ok && a_eq_x;
    assign take_s = !skip && !r_ins_done && (!a_ok || s_le_a);
    assign w      = take_s ? r_s : a;
    assign wr_en  = step && !skip;
    assign mid    = r_n >> 1;

    // merge sequencing
    always_comb begin
        n_k        = r_k;
        n_r        = r_r;
        n_m        = r_m;
        n_n        = r_n;
        n_ins_done = r_ins_done;
        n_rem_done = r_rem_done;
        n_bank     = r_bank;
        if (i_ctl.start) begin
            n_k        = '0;
            n_r        = '0;
            n_m        = i_ring.m;
            n_n        = i_ring.n;
            n_ins_done = 1'b0;
            n_rem_done = !i_ring.full;
        end else if (step) begin
            if (skip) begin
                n_r        = r_r + t_cnt'(1);
                n_rem_done = 1'b1;
            end else begin
                n_k = r_k + t_cnt'(1);
                if (take_s) begin
                    n_ins_done = 1'b1;
                end else begin
                    n_r = r_r + t_cnt'(1);
                end
            end
        end else if (i_ctl.run) begin
            n_bank = !r_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k        <= '0;
            r_r        <= '0;
            r_m        <= '0;
            r_n        <= '0;
            r_ins_done <= 1'b0;
            r_rem_done <= 1'b0;
            r_bank     <= 1'b0;
        end else begin
            r_k        <= n_k;
            r_r        <= n_r;
            r_m        <= n_m;
            r_n        <= n_n;
            r_ins_done <= n_ins_done;
            r_rem_done <= n_rem_done;
            r_bank     <= n_bank;
        end
    end

    // new list goes to the other bank
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (r_bank) begin
                r_b0[r_k[IDX_W-1:0]] <= w;
            end else begin
                r_b1[r_k[IDX_W-1:0]] <= w;
            end
        end
    end

    // request payload and middle pair capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_s <= i_sample;
            r_x <= i_ring.old;
        end
        if (wr_en && (r_k == mid)) begin
            r_hi <= w;
        end
        if (wr_en && (r_k == mid - t_cnt'(1))) begin
            r_lo <= w;
        end
    end

    assign o_sts.done = done;
    assign o_sts.lo   = r_lo;
    assign o_sts.hi   = r_hi;
    assign o_sts.n    = r_n;

    // the oldest value may be the last old entry and simply never get copied
    `SWM_CHECK_IMP(a_merge_complete, i_ctl.run && done, r_ins_done, "merge ended early")
    `SWM_CHECK(a_wr_bound, r_k <= r_n, "write pointer past list end")
    `SWM_CHECK(a_rd_bound, r_r <= r_m, "read pointer past list end")

endmodule

`default_nettype wire

@@ rtl/sliding_window_median.sv @@
// Flow: a request is accepted in S_IDLE; in S_SCAN the sorted-list merge walks one
// entry per cycle through one compare unit, with an extra step to drop the oldest
// once the window is full (none when the oldest value sits last in the sorted list);
// S_SUM loads the output register, waiting while it holds an unaccepted result.
// The next request is taken only after S_SUM, back in S_IDLE.
// Reset: synchronous active-low i_rst_n empties the window and the output stage.
// ---------------------------------------------------------------------------
// sliding_window_median
// Median of the last WINDOW signed samples, reported doubled with fill count.
// ---------------------------------------------------------------------------
`default_nettype none

module sliding_window_median (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [15:0] sample
    input  logic [swm_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [16:0] median_doubled, [20:17] fill_count, [23:21] zero
    output logic [swm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import swm_pkg::*;

    `include "sliding_window_median_assert.svh"

    t_swm_state r_state;
    t_swm_state n_state;
    t_ring_sts  ring_sts;
    t_sort_ctl  sort_ctl;
    t_sort_sts  sort_sts;
    t_sample    sample;
    logic       accept;
    logic       out_load;
    t_med       med;
    logic       r_out_valid;
    t_med       r_out_med;
    logic [FILL_W-1:0] r_out_fill;

    assign sample = t_sample'(s_axis_tdata[SAMPLE_W-1:0]);
    assign accept = s_axis_tvalid && s_axis_tready;

    swm_ring u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (accept),
        .i_sample (sample),
        .o_sts    (ring_sts)
    );

    swm_sort u_sort (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (sort_ctl),
        .i_sample (sample),
        .i_ring   (ring_sts),
        .o_sts    (sort_sts)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (sort_sts.done) n_state = S_SUM;
            end
            S_SUM: begin
                if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready  = 1'b0;
        sort_ctl.start = 1'b0;
        sort_ctl.run   = 1'b0;
        out_load       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready  = 1'b1;
                sort_ctl.start = s_axis_tvalid;
            end
            S_SCAN: begin
                sort_ctl.run = 1'b1;
            end
            S_SUM: begin
                out_load = !r_out_valid || m_axis_tready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // twice the median: doubled middle for odd count, pair sum for even
    always_comb begin
        if (sort_sts.n[0]) begin
            med = {sort_sts.hi, 1'b0};
        end else begin
            med = {sort_sts.lo[SAMPLE_W-1], sort_sts.lo}
                + {sort_sts.hi[SAMPLE_W-1], sort_sts.hi};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_med  <= med;
            r_out_fill <= FILL_W'(sort_sts.n);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_fill, r_out_med};

    `SWM_CHECK_NXT(a_load_shows, out_load, m_axis_tvalid && (r_out_fill != '0), "result not presented")

endmodule

`default_nettype wire
